FILE: rtl/core/euler_transform_matrix_defines.svh
// Assertion macros for the Euler transform matrix block.
`ifndef EULER_TRANSFORM_MATRIX_DEFINES_SVH
`define EULER_TRANSFORM_MATRIX_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define ETM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Condition that must never hold outside reset.
`define ETM_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error(msg);

`endif

FILE: rtl/core/etm_pkg.sv
// Types, constants and tables shared by the Euler transform matrix block.
`default_nettype none
package etm_pkg;

	localparam int CORDIC_STEPS_DEF = 20;
	localparam int ATAN_N = 30;
	localparam int ZW = 33;
	localparam int TW = 32;
	localparam int RW = 34;
	localparam int PN = 14;
	localparam int QW = 36;

	localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam logic signed [TW-1:0] CORDIC_X0 = 32'sd652032874;
	localparam logic signed [RW-1:0] DEG90 = 34'sd5898240;
	localparam logic signed [RW-1:0] DEG180 = 34'sd11796480;
	localparam logic signed [RW-1:0] DEG360 = 34'sd23592960;
	localparam logic signed [8:0] RECIP360 = 9'sd182;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] angle_x;
		logic signed [31:0] angle_y;
		logic signed [31:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} item_t;

	typedef struct packed {
		logic [1:0]         column_index;
		logic signed [31:0] elem0;
		logic signed [31:0] elem1;
		logic signed [31:0] elem2;
		logic signed [31:0] elem3;
		logic               last_column;
		logic               error_flag;
	} res_t;

	// lane 0 yaw, lane 1 pitch, lane 2 roll
	typedef struct packed {
		logic                 mode;
		logic [2:0]           neg;
		logic [2:0][ZW-1:0]   z;
		logic [2:0][31:0]     scale;
		logic [2:0][31:0]     trans;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_PROD,
		ST_COL,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	// atan(2^-i) in degrees, Q8.24
	function automatic logic [30:0] atan_deg(input logic [4:0] i);
		logic [30:0] v;
		case (i)
			5'd0: v = 31'd754974720;
			5'd1: v = 31'd445687602;
			5'd2: v = 31'd235489088;
			5'd3: v = 31'd119537938;
			5'd4: v = 31'd60000934;
			5'd5: v = 31'd30029717;
			5'd6: v = 31'd15018523;
			5'd7: v = 31'd7509720;
			5'd8: v = 31'd3754917;
			5'd9: v = 31'd1877466;
			5'd10: v = 31'd938734;
			5'd11: v = 31'd469367;
			5'd12: v = 31'd234684;
			5'd13: v = 31'd117342;
			5'd14: v = 31'd58671;
			5'd15: v = 31'd29335;
			5'd16: v = 31'd14668;
			5'd17: v = 31'd7334;
			5'd18: v = 31'd3667;
			5'd19: v = 31'd1833;
			5'd20: v = 31'd917;
			5'd21: v = 31'd458;
			5'd22: v = 31'd229;
			5'd23: v = 31'd115;
			5'd24: v = 31'd57;
			5'd25: v = 31'd29;
			5'd26: v = 31'd14;
			5'd27: v = 31'd7;
			5'd28: v = 31'd4;
			5'd29: v = 31'd2;
			default: v = 31'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/etm_fifo.sv
// Small register queue used between the block's parts.
`default_nettype none
module etm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] dout
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/etm_front.sv
// Front end: accepts transforms and reduces the angles to the CORDIC range.
`default_nettype none
module etm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  etm_pkg::item_t item,
	output logic           job_push,
	input  logic           job_full,
	output etm_pkg::job_t  job
);
	import etm_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	logic                    adv;
	item_t                   item_s1, item_s2;
	logic signed [7:0]       q_s1 [3];
	logic signed [RW-1:0]    r_s2 [3];
	job_t                    job_s3;
	logic signed [31:0]      ang [3];
	logic signed [31:0]      ang_s1 [3];
	logic signed [24:0]      qp [3];
	logic signed [RW-1:0]    qm [3];
	logic signed [RW-1:0]    r1 [3];
	logic signed [RW-1:0]    r2 [3];
	logic signed [RW-1:0]    r3 [3];
	logic [2:0]              neg;

	assign adv      = !v_s3 || !job_full;
	assign full     = !adv;
	assign job_push = v_s3 && !job_full;
	assign job      = job_s3;

	assign ang[0]    = item.angle_y;
	assign ang[1]    = item.angle_x;
	assign ang[2]    = item.angle_z;
	assign ang_s1[0] = item_s1.angle_y;
	assign ang_s1[1] = item_s1.angle_x;
	assign ang_s1[2] = item_s1.angle_z;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			qp[k] = $signed(ang[k][31:16]) * RECIP360;
			qm[k] = RW'(q_s1[k]) * DEG360;
			r1[k] = r_s2[k];
			if (r_s2[k] < 0) begin
				r1[k] = r_s2[k] + DEG360;
			end else if (r_s2[k] >= DEG360) begin
				r1[k] = r_s2[k] - DEG360;
			end
			r2[k] = (r1[k] >= DEG180) ? r1[k] - DEG360 : r1[k];
			r3[k]  = r2[k];
			neg[k] = 1'b0;
			if (r2[k] > DEG90) begin
				r3[k]  = r2[k] - DEG180;
				neg[k] = 1'b1;
			end else if (r2[k] < -DEG90) begin
				r3[k]  = r2[k] + DEG180;
				neg[k] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			item_s2 <= item_s1;
			for (int k = 0; k < 3; k++) begin
				q_s1[k] <= qp[k][23:16];
				r_s2[k] <= RW'(ang_s1[k]) - qm[k];
				job_s3.z[k] <= {r3[k][ZW-9:0], 8'b0};
			end
			job_s3.mode  <= item_s2.mode;
			job_s3.neg   <= neg;
			job_s3.scale <= {item_s2.scale_z, item_s2.scale_y, item_s2.scale_x};
			job_s3.trans <= {item_s2.trans_z, item_s2.trans_y, item_s2.trans_x};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/etm_cordic.sv
// Iterative three-lane CORDIC giving cosine and sine of the reduced angles.
`default_nettype none
module etm_cordic #(
	parameter int STEPS = etm_pkg::CORDIC_STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [2:0][etm_pkg::ZW-1:0]    z,
	input  logic [2:0]                     neg,
	output logic                           done,
	output logic [2:0][etm_pkg::TW-1:0]    cos_v,
	output logic [2:0][etm_pkg::TW-1:0]    sin_v
);
	import etm_pkg::*;

	localparam int N  = (STEPS > ATAN_N) ? ATAN_N : STEPS;
	localparam int IW = $clog2(N);

	logic signed [TW-1:0] x_q [3];
	logic signed [TW-1:0] y_q [3];
	logic signed [ZW-1:0] z_q [3];
	logic [2:0]           neg_q;
	logic [IW-1:0]        i_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [ZW-1:0] at_s;

	assign at_s = ZW'(atan_deg(5'(i_q)));
	assign done = done_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cos_v[k] = neg_q[k] ? -x_q[k] : x_q[k];
			sin_v[k] = neg_q[k] ? -y_q[k] : y_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == IW'(N - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= neg;
			for (int k = 0; k < 3; k++) begin
				x_q[k] <= CORDIC_X0;
				y_q[k] <= '0;
				z_q[k] <= $signed(z[k]);
			end
		end else if (busy_q) begin
			for (int k = 0; k < 3; k++) begin
				if (z_q[k] >= 0) begin
					x_q[k] <= x_q[k] - (y_q[k] >>> i_q);
					y_q[k] <= y_q[k] + (x_q[k] >>> i_q);
					z_q[k] <= z_q[k] - at_s;
				end else begin
					x_q[k] <= x_q[k] + (y_q[k] >>> i_q);
					y_q[k] <= y_q[k] - (x_q[k] >>> i_q);
					z_q[k] <= z_q[k] + at_s;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/etm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module etm_div #(
	parameter int NW = 36,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	assign sh       = {rem_q, quo_q[NW-1]};
	assign ge       = (sh >= {1'b0, den_q});
	assign diff     = sh - {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/etm_back.sv
// Back end: rotation products, per-column scaling or division, column results.
`default_nettype none
module etm_back #(
	parameter int CORDIC_STEPS = etm_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_empty,
	output logic          job_pop,
	input  etm_pkg::job_t job,
	output logic          res_push,
	input  logic          res_full,
	output etm_pkg::res_t res
);
	import etm_pkg::*;

	localparam logic [3:0] LAST_STEP = 4'(PN - 1);

	back_state_t state_q, state_d;
	job_t                job_q;
	logic signed [TW-1:0] c_q [3];
	logic signed [TW-1:0] s_q [3];
	logic signed [TW-1:0] p_q [PN];
	logic [3:0]           step_q;
	logic                 phase_q;
	logic [1:0]           col_q;
	logic signed [63:0]   prod_s1;
	logic signed [64:0]   mp_s1 [3];
	res_t                 res_q;

	logic                 cstart, cdone;
	logic [2:0][TW-1:0]   cos_v, sin_v;
	logic                 dstart;
	logic [2:0]           ddone;
	logic [2:0][QW-1:0]   dquo;
	logic [2:0][QW-1:0]   dnum;
	logic [2:0][31:0]     dden;

	logic signed [TW-1:0] op_a, op_b;
	logic signed [63:0]   prod_r;
	logic signed [32:0]   t [3][3];
	logic signed [32:0]   tc [3];
	logic signed [31:0]   sc;
	logic                 err;
	logic signed [31:0]   e_mul [3];
	logic signed [31:0]   e_div [3];
	logic signed [64:0]   mr [3];
	logic signed [34:0]   tn [3];
	logic [34:0]          mag [3];
	logic [31:0]          den_abs;
	logic                 ngt [3];
	logic [QW-1:0]        q [3];
	logic                 is_mode1;

	assign is_mode1 = job_q.mode;
	assign err = is_mode1 && (job_q.scale[0] == '0 || job_q.scale[1] == '0 ||
		job_q.scale[2] == '0);
	assign res = res_q;

	etm_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cstart),
		.z      (job.z),
		.neg    (job.neg),
		.done   (cdone),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	for (genvar g = 0; g < 3; g++) begin : g_div
		etm_div #(.NW(QW), .DW(32)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (dstart),
			.dividend (dnum[g]),
			.divisor  (dden[g]),
			.done     (ddone[g]),
			.quotient (dquo[g])
		);
	end

	// rotation entries, lane 0 yaw (1), lane 1 pitch (2), lane 2 roll (3)
	always_comb begin
		t[0][0] = 33'(p_q[0]) + 33'(p_q[2]);
		t[0][1] = 33'(p_q[3]);
		t[0][2] = 33'(p_q[5]) - 33'(p_q[6]);
		t[1][0] = 33'(p_q[7]) - 33'(p_q[8]);
		t[1][1] = 33'(p_q[9]);
		t[1][2] = 33'(p_q[10]) + 33'(p_q[11]);
		t[2][0] = 33'(p_q[12]);
		t[2][1] = -33'(s_q[1]);
		t[2][2] = 33'(p_q[13]);
	end

	always_comb begin
		case (col_q)
			2'd0: begin
				tc[0] = t[0][0]; tc[1] = t[0][1]; tc[2] = t[0][2];
				sc = $signed(job_q.scale[0]);
			end
			2'd1: begin
				tc[0] = t[1][0]; tc[1] = t[1][1]; tc[2] = t[1][2];
				sc = $signed(job_q.scale[1]);
			end
			default: begin
				tc[0] = t[2][0]; tc[1] = t[2][1]; tc[2] = t[2][2];
				sc = $signed(job_q.scale[2]);
			end
		endcase
	end

	always_comb begin
		unique case (step_q)
			4'd0: begin op_a = c_q[0]; op_b = c_q[2]; end
			4'd1: begin op_a = s_q[0]; op_b = s_q[1]; end
			4'd2: begin op_a = p_q[1]; op_b = s_q[2]; end
			4'd3: begin op_a = c_q[1]; op_b = s_q[2]; end
			4'd4: begin op_a = c_q[0]; op_b = s_q[1]; end
			4'd5: begin op_a = p_q[4]; op_b = s_q[2]; end
			4'd6: begin op_a = c_q[2]; op_b = s_q[0]; end
			4'd7: begin op_a = p_q[6]; op_b = s_q[1]; end
			4'd8: begin op_a = c_q[0]; op_b = s_q[2]; end
			4'd9: begin op_a = c_q[1]; op_b = c_q[2]; end
			4'd10: begin op_a = p_q[0]; op_b = s_q[1]; end
			4'd11: begin op_a = s_q[0]; op_b = s_q[2]; end
			4'd12: begin op_a = c_q[1]; op_b = s_q[0]; end
			4'd13: begin op_a = c_q[0]; op_b = c_q[1]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	assign prod_r  = (prod_s1 + 64'sd536870912) >>> 30;
	assign den_abs = sc[31] ? 32'(-sc) : 32'(sc);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			mr[r]    = (mp_s1[r] + 65'sd536870912) >>> 30;
			if (mr[r] > 65'(SAT_MAX)) begin
				e_mul[r] = SAT_MAX;
			end else if (mr[r] < 65'(SAT_MIN)) begin
				e_mul[r] = SAT_MIN;
			end else begin
				e_mul[r] = mr[r][31:0];
			end
			tn[r]    = {tc[r][32], tc[r], 1'b0} <<< 1;
			mag[r]   = tc[r][32] ? 35'(-tn[r]) : 35'(tn[r]);
			dnum[r]  = QW'(mag[r]) + QW'(den_abs >> 1);
			dden[r]  = den_abs;
			ngt[r]   = tc[r][32] != sc[31];
			q[r]     = dquo[r];
			if (sc == '0) begin
				if (tc[r] > 0) begin
					e_div[r] = SAT_MAX;
				end else if (tc[r] < 0) begin
					e_div[r] = SAT_MIN;
				end else begin
					e_div[r] = '0;
				end
			end else if (!ngt[r]) begin
				e_div[r] = (q[r] > QW'(32'h7fffffff)) ? SAT_MAX : $signed(q[r][31:0]);
			end else begin
				e_div[r] = (q[r] > QW'(32'h80000000)) ? SAT_MIN : -$signed(q[r][31:0]);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (!job_empty) state_d = ST_ROT;
			ST_ROT:  if (cdone) state_d = ST_PROD;
			ST_PROD: if (phase_q && step_q == LAST_STEP) state_d = ST_COL;
			ST_COL: begin
				if (is_mode1) begin
					state_d = ST_DIV;
				end else if (phase_q) begin
					state_d = ST_EMIT;
				end
			end
			ST_DIV:  if (&ddone) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!res_full) begin
					if (res_q.last_column) begin
						state_d = ST_IDLE;
					end else if (!(!is_mode1 && col_q == 2'd2)) begin
						state_d = ST_COL;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		job_pop  = 1'b0;
		cstart   = 1'b0;
		dstart   = 1'b0;
		res_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_pop = !job_empty;
				cstart  = !job_empty;
			end
			ST_COL:  dstart = is_mode1;
			ST_EMIT: res_push = !res_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			phase_q <= 1'b0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					step_q  <= '0;
					phase_q <= 1'b0;
					col_q   <= '0;
				end
				ST_PROD: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_COL: if (!is_mode1) phase_q <= !phase_q;
				ST_EMIT: begin
					if (res_push && !res_q.last_column) begin
						col_q <= col_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == ST_ROT && cdone) begin
			for (int k = 0; k < 3; k++) begin
				c_q[k] <= $signed(cos_v[k]);
				s_q[k] <= $signed(sin_v[k]);
			end
		end
		if (state_q == ST_PROD) begin
			if (!phase_q) begin
				prod_s1 <= op_a * op_b;
			end else begin
				p_q[step_q] <= prod_r[31:0];
			end
		end
		if (state_q == ST_COL && !is_mode1) begin
			if (!phase_q) begin
				for (int r = 0; r < 3; r++) begin
					mp_s1[r] <= tc[r] * sc;
				end
			end else begin
				res_q.column_index <= col_q;
				res_q.elem0        <= e_mul[0];
				res_q.elem1        <= e_mul[1];
				res_q.elem2        <= e_mul[2];
				res_q.elem3        <= '0;
				res_q.last_column  <= 1'b0;
				res_q.error_flag   <= 1'b0;
			end
		end
		if (state_q == ST_DIV && (&ddone)) begin
			res_q.column_index <= col_q;
			res_q.elem0        <= e_div[0];
			res_q.elem1        <= e_div[1];
			res_q.elem2        <= e_div[2];
			res_q.elem3        <= '0;
			res_q.last_column  <= (col_q == 2'd2);
			res_q.error_flag   <= err;
		end
		if (res_push && !is_mode1 && col_q == 2'd2) begin
			res_q.column_index <= 2'd3;
			res_q.elem0        <= $signed(job_q.trans[0]);
			res_q.elem1        <= $signed(job_q.trans[1]);
			res_q.elem2        <= $signed(job_q.trans[2]);
			res_q.elem3        <= ONE_Q16;
			res_q.last_column  <= 1'b1;
			res_q.error_flag   <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/euler_transform_matrix.sv
// Top level of the Euler angle model and normal matrix block.
`default_nettype none
`include "euler_transform_matrix_defines.svh"
// Takes one transform per push and returns its matrix one column per result, column 0
// first: four columns in model mode, three in normal mode. A three-stage front reduces
// the angles and queues up to two transforms, so pushes keep being taken while the back
// end works; results wait in a two-entry output queue. The back end handles one
// transform at a time: the three-lane CORDIC, then the fourteen rotation products
// through one shared multiplier, then each column scaled plus the translation column
// in model mode, or each column divided by the three 36-step restoring dividers in
// normal mode.
module euler_transform_matrix #(
	parameter int CORDIC_STEPS = etm_pkg::CORDIC_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  etm_pkg::item_t item,
	output logic           empty,
	input  logic           pop,
	output etm_pkg::res_t  result
);
	import etm_pkg::*;

	logic  f_push, f_full;
	job_t  f_job;
	logic  job_pop, job_empty;
	job_t  job_head;
	logic  res_push, res_full;
	res_t  res_back;
	logic [$bits(res_t)-1:0] res_bits;
	logic [$bits(job_t)-1:0] job_bits;
	logic  col3_out;
	logic  col3_ok;

	etm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_push (f_push),
		.job_full (f_full),
		.job      (f_job)
	);

	etm_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (f_full),
		.din    (f_job),
		.pop    (job_pop),
		.empty  (job_empty),
		.dout   (job_bits)
	);
	assign job_head = job_t'(job_bits);

	etm_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.job       (job_head),
		.res_push  (res_push),
		.res_full  (res_full),
		.res       (res_back)
	);

	etm_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.din    (res_back),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_bits)
	);
	assign result = res_t'(res_bits);

	assign col3_out = !empty && result.column_index == 2'd3;
	assign col3_ok  = result.last_column && !result.error_flag;

	`ETM_ASSERT_NEVER(a_res_overflow, res_push && res_full, "result pushed into full queue")
	`ETM_ASSERT_NEVER(a_job_underflow, job_pop && job_empty, "job popped from empty queue")
	`ETM_ASSERT_IMP(a_col3_last, col3_out, col3_ok, "column 3 must close the matrix")
endmodule
`default_nettype wire

FILE: verif/euler_transform_matrix_test.sv
// Self-checking testbench for the Euler transform matrix block.
`default_nettype none
module euler_transform_matrix_test;
	timeunit 1ns;
	timeprecision 1ps;
	import etm_pkg::*;

	localparam int STEPS = CORDIC_STEPS_DEF;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint QUARTER_TURN = 64'sd5898240;
	localparam longint GAIN_START = 64'sd652032874;
	localparam logic MODE_MODEL = 1'b0;
	localparam logic MODE_NORMAL = 1'b1;
	localparam int N_RANDOM = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	item_t item = '0;
	res_t result;

	res_t columns_due[$];
	int errors = 0;
	bit hold_off = 1'b0;
	bit sender_done = 1'b0;

	euler_transform_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint mul_q30(longint a, longint b);
		return shr_floor(a * b + (64'sd1 <<< 29), 30);
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return SAT_MAX;
		if (v < -64'sd2147483648)
			return SAT_MIN;
		return v[31:0];
	endfunction

	function automatic void sin_cos(longint a, output longint c, output longint s);
		longint r, x, y, z, dx, dy;
		bit flip;
		r = a % FULL_TURN;
		flip = 1'b0;
		x = GAIN_START;
		y = 0;
		if (r < 0)
			r += FULL_TURN;
		if (r >= HALF_TURN)
			r -= FULL_TURN;
		if (r > QUARTER_TURN) begin
			r -= HALF_TURN;
			flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r += HALF_TURN;
			flip = 1'b1;
		end
		z = r * 256;
		for (int i = 0; i < STEPS && i < 30; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= longint'(atan_deg(i[4:0]));
			end else begin
				x += dx;
				y -= dy;
				z += longint'(atan_deg(i[4:0]));
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [31:0] divide_by_scale(longint t, longint sc);
		longint num, den, q;
		bit neg;
		if (sc == 0)
			return t > 0 ? SAT_MAX : (t < 0 ? SAT_MIN : 32'sd0);
		num = t * 4;
		neg = (num < 0) != (sc < 0);
		if (num < 0)
			num = -num;
		den = sc < 0 ? -sc : sc;
		q = (num + den / 2) / den;
		return clamp32(neg ? -q : q);
	endfunction

	task automatic predict_matrix(input item_t it);
		longint c1, s1, c2, s2, c3, s3;
		longint rot[3][3];
		longint sc[3];
		logic signed [31:0] e[3];
		res_t col;
		bit bad;
		sin_cos(it.angle_y, c1, s1);
		sin_cos(it.angle_x, c2, s2);
		sin_cos(it.angle_z, c3, s3);
		sc[0] = it.scale_x;
		sc[1] = it.scale_y;
		sc[2] = it.scale_z;
		rot[0][0] = mul_q30(c1, c3) + mul_q30(mul_q30(s1, s2), s3);
		rot[0][1] = mul_q30(c2, s3);
		rot[0][2] = mul_q30(mul_q30(c1, s2), s3) - mul_q30(c3, s1);
		rot[1][0] = mul_q30(mul_q30(c3, s1), s2) - mul_q30(c1, s3);
		rot[1][1] = mul_q30(c2, c3);
		rot[1][2] = mul_q30(mul_q30(c1, c3), s2) + mul_q30(s1, s3);
		rot[2][0] = mul_q30(c2, s1);
		rot[2][1] = -s2;
		rot[2][2] = mul_q30(c1, c2);
		bad = it.mode == MODE_NORMAL && (sc[0] == 0 || sc[1] == 0 || sc[2] == 0);
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++)
				e[r] = it.mode == MODE_MODEL ?
					clamp32(shr_floor(rot[k][r] * sc[k] + (64'sd1 <<< 29), 30)) :
					divide_by_scale(rot[k][r], sc[k]);
			col.column_index = k[1:0];
			col.elem0 = e[0];
			col.elem1 = e[1];
			col.elem2 = e[2];
			col.elem3 = '0;
			col.last_column = it.mode == MODE_NORMAL && k == 2;
			col.error_flag = bad;
			columns_due.push_back(col);
		end
		if (it.mode == MODE_MODEL) begin
			col.column_index = 2'd3;
			col.elem0 = it.trans_x;
			col.elem1 = it.trans_y;
			col.elem2 = it.trans_z;
			col.elem3 = ONE_Q16;
			col.last_column = 1'b1;
			col.error_flag = 1'b0;
			columns_due.push_back(col);
		end
	endtask

	task automatic send_transform(input item_t it);
		item <= it;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		predict_matrix(it);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return 32'sd0;
			3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sd131072;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_angle();
		if ($urandom_range(0, 2) == 0)
			return $urandom;
		return $signed($urandom_range(0, 720)) * ONE_Q16 - 32'sd23592960
			+ $signed($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 0);
	endfunction

	initial begin
		item_t directed[$];
		item_t it;
		int gap;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		it = '{MODE_MODEL, 0, 0, 0, ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0};
		directed.push_back(it);
		it.mode = MODE_NORMAL;
		directed.push_back(it);
		it = '{MODE_MODEL, 90 * ONE_Q16, -90 * ONE_Q16, 180 * ONE_Q16,
			SAT_MAX, SAT_MIN, -ONE_Q16, SAT_MAX, SAT_MIN, 32'sd1};
		directed.push_back(it);
		it = '{MODE_MODEL, SAT_MAX, SAT_MIN, 360 * ONE_Q16,
			SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, -32'sd1};
		directed.push_back(it);
		it = '{MODE_NORMAL, 30 * ONE_Q16, 45 * ONE_Q16, -180 * ONE_Q16,
			32'sd0, ONE_Q16, 2 * ONE_Q16, 0, 0, 0};
		directed.push_back(it);
		it = '{MODE_NORMAL, 0, 0, 0, 32'sd0, 32'sd0, 32'sd0, 0, 0, 0};
		directed.push_back(it);
		it = '{MODE_NORMAL, 270 * ONE_Q16, -270 * ONE_Q16, 91 * ONE_Q16,
			32'sd1, SAT_MIN, SAT_MAX, 0, 0, 0};
		directed.push_back(it);
		it = '{MODE_NORMAL, -91 * ONE_Q16, 179 * ONE_Q16, SAT_MIN,
			-32'sd1, 32'sd2, ONE_Q16 / 2, SAT_MAX, SAT_MAX, SAT_MAX};
		directed.push_back(it);
		it = '{MODE_MODEL, -32'sd1, 32'sd1, 32'sh55555555,
			32'sh2aaaaaaa, -32'sh2aaaaaaa, 32'sh55555555, 32'sh2aaaaaaa, 0, 0};
		directed.push_back(it);
		foreach (directed[i])
			send_transform(directed[i]);
		for (int n = 0; n < N_RANDOM; n++) begin
			it.mode = 1'($urandom_range(0, 1));
			it.angle_x = rand_angle();
			it.angle_y = rand_angle();
			it.angle_z = rand_angle();
			it.scale_x = $urandom_range(0, 9) == 0 ? 32'sd0 : rand_word();
			it.scale_y = $urandom_range(0, 9) == 0 ? 32'sd0 : rand_word();
			it.scale_z = $urandom_range(0, 9) == 0 ? 32'sd0 : rand_word();
			it.trans_x = rand_word();
			it.trans_y = rand_word();
			it.trans_z = rand_word();
			if (n == 100)
				hold_off = 1'b1;
			if (n == 200) begin
				push <= 1'b0;
				wait (columns_due.size() == 0);
				@(negedge clk);
			end
			if (n > 120 && $urandom_range(0, 5) == 0) begin
				push <= 1'b0;
				gap = $urandom_range(1, 200);
				repeat (gap) @(negedge clk);
			end
			send_transform(it);
		end
		push <= 1'b0;
		sender_done = 1'b1;
	end

	initial begin
		int stall = 0;
		bit held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (2000) @(negedge clk);
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					stall = $urandom_range(1, 60);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && pop && !empty) begin
			if (columns_due.size() == 0) begin
				$display("%0t: column with no transaction waiting: %p", $time, result);
				errors++;
			end else begin
				want = columns_due.pop_front();
				if (result !== want) begin
					$display("%0t: column mismatch expected %p actual %p",
						$time, want, result);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (sender_done && columns_due.size() == 0);
		repeat (400) @(posedge clk);
		if (errors == 0 && columns_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
